/* hdl/wjd_pkg.sv */
// Shared types and constants for the weighted joint distance argmin block.
package wjd_pkg;

    localparam int JOINTS      = 6;
    localparam int ANGLE_W     = 16;
    localparam int WEIGHT_W    = 12;
    localparam int PROD_W      = 28;
    localparam int COST_W      = 31;
    localparam int SLOT_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_CAND  = 1'b1;

    typedef logic [COST_W-1:0]                   cost_t;
    typedef logic [JOINTS-1:0][ANGLE_W-1:0]      pose_t;
    typedef logic [JOINTS-1:0][WEIGHT_W-1:0]     weights_t;
    typedef logic [JOINTS-1:0][PROD_W-1:0]       prods_t;

    localparam weights_t WEIGHT_RESET = {12'd51, 12'd51, 12'd128, 12'd768, 12'd1280, 12'd1280};

    typedef struct packed {
        logic  is_start;
        logic  last;
        pose_t pose;
        cost_t cost;
    } item_t;

endpackage

/* hdl/wjd_front.sv */
// Front end: accepts items, scores candidates in two stages and feeds the queue.
module wjd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         req_type,
    input  wjd_pkg::pose_t               cand,
    input  logic                         final_candidate,
    input  wjd_pkg::weights_t            weights,
    input  logic [wjd_pkg::QCNT_W-1:0]   q_count,
    output logic                         item_valid,
    output wjd_pkg::item_t               item
);
    import wjd_pkg::*;

    logic                              accept;
    logic [QCNT_W:0]                   pending;
    pose_t                             start_pose_reg;
    logic                              a_valid_reg;
    logic                              a_start_reg;
    logic                              a_last_reg;
    pose_t                             a_pose_reg;
    prods_t                            a_prod_reg;
    prods_t                            a_prod_next;
    logic signed [JOINTS-1:0][ANGLE_W:0] diff;
    logic [JOINTS-1:0][ANGLE_W:0]      mag;
    cost_t                             cost_sum;
    logic                              b_valid_reg;
    item_t                             b_item_reg;

    assign pending = {1'b0, q_count} + {{QCNT_W{1'b0}}, a_valid_reg}
                   + {{QCNT_W{1'b0}}, b_valid_reg};
    assign in_stall = (pending >= (QCNT_W + 1)'(QUEUE_DEPTH));
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        for (int j = 0; j < JOINTS; j++)
        begin
            diff[j] = $signed({start_pose_reg[j][ANGLE_W-1], start_pose_reg[j]})
                    - $signed({cand[j][ANGLE_W-1], cand[j]});
            mag[j] = diff[j][ANGLE_W] ? (~diff[j] + 1'b1) : diff[j];
            a_prod_next[j] = PROD_W'(mag[j][ANGLE_W-1:0]) * PROD_W'(weights[j]);
        end
    end

    always_comb
    begin
        cost_sum = '0;
        for (int j = 0; j < JOINTS; j++)
        begin
            cost_sum = cost_sum + COST_W'(a_prod_reg[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pose_reg <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            if (accept && req_type == REQ_START)
            begin
                start_pose_reg <= cand;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_start_reg <= (req_type == REQ_START);
            a_last_reg  <= final_candidate;
            a_pose_reg  <= cand;
            a_prod_reg  <= a_prod_next;
        end
        if (a_valid_reg)
        begin
            b_item_reg.is_start <= a_start_reg;
            b_item_reg.last     <= a_last_reg;
            b_item_reg.pose     <= a_pose_reg;
            b_item_reg.cost     <= cost_sum;
        end
    end

    assign item_valid = b_valid_reg;
    assign item       = b_item_reg;

endmodule

/* hdl/wjd_queue.sv */
// Short first-in first-out queue between the scoring front end and the selector.
module wjd_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  wjd_pkg::item_t               push_item,
    input  logic                         pop,
    output wjd_pkg::item_t               pop_item,
    output logic                         not_empty,
    output logic [wjd_pkg::QCNT_W-1:0]   count
);
    import wjd_pkg::*;

    item_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item  = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

/* hdl/wjd_back.sv */
// Back end: keeps the lowest-cost candidate of a run and registers the result.
module wjd_back #(
    parameter int MAX_CANDIDATES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  wjd_pkg::item_t                item,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output wjd_pkg::pose_t                best_pose,
    output wjd_pkg::cost_t                best_cost,
    output logic [wjd_pkg::SLOT_W-1:0]    best_slot
);
    import wjd_pkg::*;

    localparam int CNT_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;

    logic                    have_kept_reg;
    logic [CNT_W-1:0]        seen_count_reg;
    logic [CNT_W-1:0]        seen_count_next;
    logic [CNT_W+SLOT_W-1:0] seen_ext;
    pose_t                   kept_pose_reg;
    cost_t                   kept_cost_reg;
    logic [SLOT_W-1:0]       kept_slot_reg;
    logic                    take;
    logic                    is_cand;
    logic                    emit;
    pose_t                   sel_pose;
    cost_t                   sel_cost;
    logic [SLOT_W-1:0]       sel_slot;
    logic                    out_valid_reg;
    pose_t                   out_pose_reg;
    cost_t                   out_cost_reg;
    logic [SLOT_W-1:0]       out_slot_reg;

    assign pop     = item_valid && (!out_valid_reg || !out_stall);
    assign is_cand = !item.is_start;
    assign emit    = pop && is_cand && item.last;
    assign take    = !have_kept_reg || (item.cost < kept_cost_reg);

    assign seen_ext        = {{SLOT_W{1'b0}}, seen_count_reg};
    assign seen_count_next = (seen_count_reg == CNT_W'(MAX_CANDIDATES - 1))
                           ? '0 : seen_count_reg + 1'b1;

    assign sel_pose = take ? item.pose : kept_pose_reg;
    assign sel_cost = take ? item.cost : kept_cost_reg;
    assign sel_slot = take ? seen_ext[SLOT_W-1:0] : kept_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_kept_reg  <= 1'b0;
            seen_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                if (!is_cand || item.last)
                begin
                    have_kept_reg  <= 1'b0;
                    seen_count_reg <= '0;
                end
                else
                begin
                    have_kept_reg  <= 1'b1;
                    seen_count_reg <= seen_count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && is_cand)
        begin
            kept_pose_reg <= sel_pose;
            kept_cost_reg <= sel_cost;
            kept_slot_reg <= sel_slot;
        end
        if (emit)
        begin
            out_pose_reg <= sel_pose;
            out_cost_reg <= sel_cost;
            out_slot_reg <= sel_slot;
        end
    end

    assign out_valid = out_valid_reg;
    assign best_pose = out_pose_reg;
    assign best_cost = out_cost_reg;
    assign best_slot = out_slot_reg;

endmodule

/* hdl/weighted_joint_distance_argmin.sv */
// Top level of the weighted L1 nearest-candidate picker with its weight registers.
// Path: the final candidate passes the two scoring stages and the queue before the result register is loaded.
// Throughput: one item per cycle; the front end stalls when the four-entry queue,
// counting the two scoring stages in flight, is full.
// Reset: asynchronous, active low; clears the start pose, the run and all valids,
// and loads the default weights.
module weighted_joint_distance_argmin #(
    parameter int MAX_CANDIDATES = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic signed [15:0]                angle_0,
    input  logic signed [15:0]                angle_1,
    input  logic signed [15:0]                angle_2,
    input  logic signed [15:0]                angle_3,
    input  logic signed [15:0]                angle_4,
    input  logic signed [15:0]                angle_5,
    input  logic                              final_candidate,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [15:0]                best_angle_0,
    output logic signed [15:0]                best_angle_1,
    output logic signed [15:0]                best_angle_2,
    output logic signed [15:0]                best_angle_3,
    output logic signed [15:0]                best_angle_4,
    output logic signed [15:0]                best_angle_5,
    output logic [30:0]                       best_cost,
    output logic [2:0]                        best_slot,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wjd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wjd_pkg::WEIGHT_W-1:0]      cfg_data
);
    import wjd_pkg::*;

    weights_t            weight_reg;
    pose_t               cand;
    pose_t               best_pose;
    logic                f_valid;
    item_t               f_item;
    logic                q_pop;
    item_t               q_item;
    logic                q_not_empty;
    logic [QCNT_W-1:0]   q_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int j = 0; j < JOINTS; j++)
            begin
                if (cfg_index == CFG_IDX_W'(j))
                begin
                    weight_reg[j] <= cfg_data;
                end
            end
        end
    end

    assign cand[0] = angle_0;
    assign cand[1] = angle_1;
    assign cand[2] = angle_2;
    assign cand[3] = angle_3;
    assign cand[4] = angle_4;
    assign cand[5] = angle_5;

    wjd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .cand            (cand),
        .final_candidate (final_candidate),
        .weights         (weight_reg),
        .q_count         (q_count),
        .item_valid      (f_valid),
        .item            (f_item)
    );

    wjd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_item (f_item),
        .pop       (q_pop),
        .pop_item  (q_item),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    wjd_back #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_not_empty),
        .item       (q_item),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .best_pose  (best_pose),
        .best_cost  (best_cost),
        .best_slot  (best_slot)
    );

    assign best_angle_0 = best_pose[0];
    assign best_angle_1 = best_pose[1];
    assign best_angle_2 = best_pose[2];
    assign best_angle_3 = best_pose[3];
    assign best_angle_4 = best_pose[4];
    assign best_angle_5 = best_pose[5];

    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("Queue occupancy exceeds its depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        f_valid |-> (q_count < QCNT_W'(QUEUE_DEPTH)) || q_pop)
        else $error("Scored item pushed into a full queue.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(q_pop && q_item.last && !q_item.is_start))
        else $error("Result raised without a final candidate leaving the queue.");

endmodule
